/* rtl/mss_pkg.sv */
`timescale 1ns / 1ps
package mss_pkg;

  localparam int MAX_DIMS   = 9;
  localparam int MAX_WINDOW = 32;
  localparam int NUM_SLOTS  = MAX_DIMS + 1;
  localparam int TAP_W      = $clog2(MAX_WINDOW);
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int ADDR_W     = SLOT_W + TAP_W;
  localparam int MEM_DEPTH  = NUM_SLOTS * MAX_WINDOW;
  localparam int FILL_W     = TAP_W + 1;
  localparam int ACC_W      = 54;
  localparam int ROOT_STEPS = 32;

  // history slot that holds the speed magnitude
  localparam logic [SLOT_W-1:0] NORM_SLOT = SLOT_W'(MAX_DIMS);

  // request modes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_WEIGHT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_DIMS = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;

  typedef struct packed {
    logic              set_val;
    logic              wr_weight;
    logic              diff_load;
    logic              push_diff;
    logic              push_norm;
    logic              sum_clear;
    logic              sum_acc;
    logic              root_init;
    logic              root_step;
    logic              mac_clear;
    logic              mac_issue;
    logic              emit;
    logic [SLOT_W-1:0] slot;
    logic [TAP_W-1:0]  tap;
  } mss_cmd_t;

  typedef struct packed {
    logic mac_busy;
  } mss_stat_t;

endpackage

/* rtl/multi_axis_speed_smoother_unit.sv */
`timescale 1ns / 1ps
// Set-value and weight requests are handled directly in the idle state.
// A tick forms the axis differences and the 32-step square root, then runs the
// one-tap-per-cycle multiply-accumulate for each result (N axes, W taps),
// N + 1 results, each held until the output is taken; one request is in work at a time.
// Reset clears control state, axis values, weights and history fill counts at once.
module multi_axis_speed_smoother_unit import mss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [4:0]         index_i,
  input  logic signed [31:0] sample_i,
  input  logic [15:0]        weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_norm_o,
  output logic [3:0]         axis_o,
  output logic signed [31:0] value_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i
);

  mss_cmd_t  cmd;
  mss_stat_t stat;

  mss_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .index_i     (index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mss_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .index_i   (index_i),
    .sample_i  (sample_i),
    .weight_i  (weight_i),
    .is_norm_o (is_norm_o),
    .axis_o    (axis_o),
    .value_o   (value_o),
    .last_o    (last_o)
  );

endmodule

/* rtl/mss_datapath.sv */
`timescale 1ns / 1ps
module mss_datapath import mss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mss_cmd_t           cmd_i,
  output mss_stat_t          stat_o,
  input  logic [4:0]         index_i,
  input  logic signed [31:0] sample_i,
  input  logic [15:0]        weight_i,
  output logic               is_norm_o,
  output logic [3:0]         axis_o,
  output logic signed [31:0] value_o,
  output logic               last_o
);

  logic signed [31:0] cur_q  [MAX_DIMS];
  logic signed [31:0] prev_q [MAX_DIMS];
  logic [15:0]        tw_q   [MAX_WINDOW];
  logic [TAP_W-1:0]   head_q [NUM_SLOTS];
  logic [FILL_W-1:0]  fill_q [NUM_SLOTS];
  logic signed [31:0] hist_mem [MEM_DEPTH];

  logic signed [31:0] d_q;
  logic [63:0]        sq_q, sum_q;
  logic [63:0]        rx_q, rres_q, rbit_q;
  logic signed [31:0] rd_q;
  logic [15:0]        w1_q;
  logic               live1_q, v1_q, v2_q;
  logic signed [48:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic               is_norm_q, last_q;
  logic [3:0]         axis_q;
  logic signed [31:0] value_q;

  logic signed [32:0] dext;
  logic signed [31:0] d_sat;
  logic [31:0]        mag;
  logic [63:0]        sq_d;
  logic [64:0]        sum_ext;
  logic [63:0]        trial;
  logic signed [31:0] norm_val;
  logic [TAP_W-1:0]   push_ptr;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic signed [31:0] wr_data;
  logic signed [48:0] prod_d;
  logic signed [ACC_W-1:0] rnd_t, rnd_s;
  logic signed [31:0] res_sat;

  // axis difference, saturated
  always_comb begin
    dext = {cur_q[cmd_i.slot][31], cur_q[cmd_i.slot]}
         - {prev_q[cmd_i.slot][31], prev_q[cmd_i.slot]};
    if (dext[32] != dext[31]) begin
      d_sat = dext[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      d_sat = dext[31:0];
    end
  end

  // square and saturating sum
  assign mag     = d_q[31] ? 32'(-d_q) : d_q;
  assign sq_d    = mag * mag;
  assign sum_ext = {1'b0, sum_q} + {1'b0, sq_q};

  // root trial and norm clamp
  assign trial    = rres_q + rbit_q;
  assign norm_val = (rres_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : rres_q[31:0];

  // history write and read addresses
  assign push_ptr = head_q[cmd_i.slot] + 1'b1;
  assign wr_addr  = {cmd_i.slot, push_ptr};
  assign wr_data  = cmd_i.push_diff ? d_q : norm_val;
  assign rd_addr  = {cmd_i.slot, head_q[cmd_i.slot] - cmd_i.tap};

  assign prod_d = rd_q * $signed({1'b0, w1_q});

  // round to Q16.16 and saturate
  always_comb begin
    rnd_t = acc_q + ACC_W'(16384);
    rnd_s = rnd_t >>> 15;
    if ((&rnd_s[ACC_W-1:31]) || !(|rnd_s[ACC_W-1:31])) begin
      res_sat = rnd_s[31:0];
    end else begin
      res_sat = rnd_s[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  assign stat_o.mac_busy = v1_q | v2_q;

  // history memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_diff || cmd_i.push_norm) begin
      hist_mem[wr_addr] <= wr_data;
    end
    rd_q <= hist_mem[rd_addr];
  end

  // axis values, weights, history pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cur_q[i]  <= '0;
        prev_q[i] <= '0;
      end
      for (int i = 0; i < MAX_WINDOW; i++) begin
        tw_q[i] <= '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (cmd_i.set_val) begin
        cur_q[index_i[SLOT_W-1:0]] <= sample_i;
      end
      if (cmd_i.wr_weight) begin
        tw_q[index_i[TAP_W-1:0]] <= weight_i;
      end
      if (cmd_i.diff_load) begin
        prev_q[cmd_i.slot] <= cur_q[cmd_i.slot];
      end
      if (cmd_i.push_diff || cmd_i.push_norm) begin
        head_q[cmd_i.slot] <= push_ptr;
        if (fill_q[cmd_i.slot] != FILL_W'(MAX_WINDOW)) begin
          fill_q[cmd_i.slot] <= fill_q[cmd_i.slot] + 1'b1;
        end
      end
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_load) d_q <= d_sat;
    if (cmd_i.push_diff) sq_q <= sq_d;
    if (cmd_i.sum_clear) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_ext[64] ? '1 : sum_ext[63:0];
    end
    if (cmd_i.root_init) begin
      rx_q   <= sum_q;
      rres_q <= '0;
      rbit_q <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.root_step) begin
      if (rx_q >= trial) begin
        rx_q   <= rx_q - trial;
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
    w1_q    <= tw_q[cmd_i.tap];
    live1_q <= {1'b0, cmd_i.tap} < fill_q[cmd_i.slot];
    prod_q  <= live1_q ? prod_d : '0;
    if (cmd_i.mac_clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + {{(ACC_W-49){prod_q[48]}}, prod_q};
    end
    if (cmd_i.emit) begin
      is_norm_q <= cmd_i.slot == NORM_SLOT;
      axis_q    <= (cmd_i.slot == NORM_SLOT) ? 4'd0 : 4'(cmd_i.slot);
      last_q    <= cmd_i.slot == '0;
      value_q   <= res_sat;
    end
  end

  assign is_norm_o = is_norm_q;
  assign axis_o    = axis_q;
  assign value_o   = value_q;
  assign last_o    = last_q;

endmodule

/* rtl/mss_controller.sv */
`timescale 1ns / 1ps
module mss_controller import mss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [4:0] index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i,
  output mss_cmd_t   cmd_o,
  input  mss_stat_t  stat_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIFF   = 4'd1;
  localparam logic [3:0] S_SQR    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_RINIT  = 4'd4;
  localparam logic [3:0] S_ROOT   = 4'd5;
  localparam logic [3:0] S_PUSHN  = 4'd6;
  localparam logic [3:0] S_MSTART = 4'd7;
  localparam logic [3:0] S_MAC    = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [3:0]        nd_cfg_q;
  logic [5:0]        ws_cfg_q;
  logic [SLOT_W-1:0] tnd_q, tnd_d;
  logic [FILL_W-1:0] tw_q, tw_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [FILL_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] nd_clamp;
  logic [FILL_W-1:0] w_clamp;

  // clamp registers to their usable range
  always_comb begin
    if (nd_cfg_q == '0) nd_clamp = SLOT_W'(1);
    else if (nd_cfg_q > 4'(MAX_DIMS)) nd_clamp = SLOT_W'(MAX_DIMS);
    else nd_clamp = SLOT_W'(nd_cfg_q);
    if (ws_cfg_q == '0) w_clamp = FILL_W'(1);
    else if (ws_cfg_q > 6'(MAX_WINDOW)) w_clamp = FILL_W'(MAX_WINDOW);
    else w_clamp = FILL_W'(ws_cfg_q);
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  // sequence one request
  always_comb begin
    state_d = state_q;
    tnd_d   = tnd_q;
    tw_d    = tw_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.slot = slot_q;
    cmd_o.tap  = cnt_q[TAP_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_SET: cmd_o.set_val = index_i < 5'(MAX_DIMS);
            MODE_WEIGHT: cmd_o.wr_weight = 1'b1;
            MODE_TICK: begin
              cmd_o.sum_clear = 1'b1;
              tnd_d   = nd_clamp;
              tw_d    = w_clamp;
              slot_d  = '0;
              state_d = S_DIFF;
            end
            default: ;
          endcase
        end
      end
      S_DIFF: begin
        cmd_o.diff_load = 1'b1;
        state_d = S_SQR;
      end
      S_SQR: begin
        cmd_o.push_diff = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.sum_acc = 1'b1;
        if (slot_q == tnd_q - 1'b1) begin
          state_d = S_RINIT;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_DIFF;
        end
      end
      S_RINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d   = '0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FILL_W'(ROOT_STEPS - 1)) state_d = S_PUSHN;
      end
      S_PUSHN: begin
        cmd_o.push_norm = 1'b1;
        cmd_o.slot = NORM_SLOT;
        slot_d  = NORM_SLOT;
        state_d = S_MSTART;
      end
      S_MSTART: begin
        cmd_o.mac_clear = 1'b1;
        cnt_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tw_q - 1'b1) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat_i.mac_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (slot_q == '0) begin
            state_d = S_IDLE;
          end else begin
            slot_d  = (slot_q == NORM_SLOT) ? tnd_q - 1'b1 : slot_q - 1'b1;
            state_d = S_MSTART;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nd_cfg_q <= 4'd1;
      ws_cfg_q <= 6'd12;
      tnd_q    <= SLOT_W'(1);
      tw_q     <= FILL_W'(1);
      slot_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      tnd_q   <= tnd_d;
      tw_q    <= tw_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_NUM_DIMS) nd_cfg_q <= cfg_data_i[3:0];
        if (cfg_index_i == REG_WINDOW) ws_cfg_q <= cfg_data_i;
      end
    end
  end

endmodule
